[rtl/wppm_pkg.sv]
// shared types and constants for the waveform period and peak meter
// field widths, period mode codes, controller to datapath command and status
// no dependencies
package wppm_pkg;

    localparam int SAMPLE_W = 8;
    localparam int THRESH_W = 9;
    localparam int COUNT_W  = 10;
    localparam int PERIOD_W = 19;
    localparam int MODE_W   = 2;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 9'd128;
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = 10'd1023;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 19'h7FFFF;

    localparam logic [MODE_W-1:0] MODE_MEAN    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HALF    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INVALID = 2'd2;

    typedef struct packed {
        logic track;     // fold an accepted sample into the capture state
        logic div_load;  // load span and divisor into the divider
        logic div_step;  // one quotient bit
        logic out_load;  // capture the result and clear the capture state
    } wppm_cmd_t;

    typedef struct packed {
        logic div_done;
    } wppm_status_t;

endpackage

[rtl/wppm_datapath.sv]
// capture tracking, bit-serial divider and result register
// depends on wppm_pkg
module wppm_datapath #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  wppm_pkg::wppm_cmd_t               cmd,
    output wppm_pkg::wppm_status_t            status,
    input  logic                              cfg_valid,
    input  logic [wppm_pkg::THRESH_W-1:0]     cfg_data,
    input  logic [wppm_pkg::SAMPLE_W-1:0]     sample,
    output logic [wppm_pkg::COUNT_W-1:0]      rising_count,
    output logic [wppm_pkg::PERIOD_W-1:0]     period_q8,
    output logic [wppm_pkg::MODE_W-1:0]       period_mode,
    output logic [wppm_pkg::SAMPLE_W-1:0]     peak_high,
    output logic [wppm_pkg::SAMPLE_W-1:0]     peak_low
);
    import wppm_pkg::*;

    localparam int IDX_W = $clog2(MAX_SAMPLES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SAMPLES - 1);
    localparam int DVD_W = IDX_W + 8;
    localparam int DSR_W = COUNT_W;
    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam int EXT_W = (IDX_W + 9 > PERIOD_W + 1) ? IDX_W + 9 : PERIOD_W + 1;

    logic [THRESH_W-1:0] thresh_reg;
    logic [SAMPLE_W-1:0] prev_reg;
    logic                have_prev_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]    first_rise_reg;
    logic [IDX_W-1:0]    last_rise_reg;
    logic [IDX_W-1:0]    first_fall_reg;
    logic                fall_found_reg;
    logic [SAMPLE_W-1:0] max_reg;
    logic [SAMPLE_W-1:0] min_reg;

    logic [DVD_W-1:0]    dvd_reg;
    logic [DSR_W-1:0]    dsr_reg;
    logic [DSR_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    cnt_reg;

    logic [COUNT_W-1:0]  out_count_reg;
    logic [PERIOD_W-1:0] out_period_reg;
    logic [MODE_W-1:0]   out_mode_reg;
    logic [SAMPLE_W-1:0] out_high_reg;
    logic [SAMPLE_W-1:0] out_low_reg;

    logic                prev_above;
    logic                cur_above;
    logic                rise;
    logic                fall;
    logic [DSR_W:0]      rem_shift;
    logic                rem_ge;
    logic [IDX_W-1:0]    half_dist;
    logic [EXT_W-1:0]    quot_ext;
    logic [EXT_W-1:0]    half_ext;
    logic [PERIOD_W-1:0] period_next;
    logic [MODE_W-1:0]   mode_next;

    assign prev_above = {1'b0, prev_reg} >= thresh_reg;
    assign cur_above  = {1'b0, sample} >= thresh_reg;
    assign rise       = have_prev_reg && !prev_above && cur_above;
    assign fall       = have_prev_reg && prev_above && !cur_above;

    assign rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, dsr_reg};

    assign half_dist = (first_fall_reg >= first_rise_reg) ? first_fall_reg - first_rise_reg
                                                          : first_rise_reg - first_fall_reg;
    assign quot_ext  = EXT_W'(dvd_reg);
    assign half_ext  = EXT_W'({half_dist, 9'd0});

    always_comb begin
        if (count_reg > COUNT_W'(2)) begin
            period_next = (quot_ext > EXT_W'(PERIOD_MAX)) ? PERIOD_MAX
                                                         : quot_ext[PERIOD_W-1:0];
            mode_next   = MODE_MEAN;
        end else if (count_reg != '0 && fall_found_reg) begin
            period_next = (half_ext > EXT_W'(PERIOD_MAX)) ? PERIOD_MAX
                                                         : half_ext[PERIOD_W-1:0];
            mode_next   = MODE_HALF;
        end else begin
            period_next = '0;
            mode_next   = MODE_INVALID;
        end
    end

    assign status.div_done = (cnt_reg == '0);

    // threshold and capture state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_RESET;
        end else if (cfg_valid) begin
            thresh_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.out_load) begin
            prev_reg       <= '0;
            have_prev_reg  <= 1'b0;
            idx_reg        <= '0;
            count_reg      <= '0;
            first_rise_reg <= '0;
            last_rise_reg  <= '0;
            first_fall_reg <= '0;
            fall_found_reg <= 1'b0;
            max_reg        <= '0;
            min_reg        <= '1;
        end else if (cmd.track) begin
            if (rise) begin
                if (count_reg == '0) begin
                    first_rise_reg <= idx_reg;
                end
                last_rise_reg <= idx_reg;
                if (count_reg < COUNT_MAX) begin
                    count_reg <= count_reg + COUNT_W'(1);
                end
            end
            if (fall && !fall_found_reg) begin
                first_fall_reg <= idx_reg;
                fall_found_reg <= 1'b1;
            end
            if (have_prev_reg && idx_reg < IDX_LAST) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            prev_reg      <= sample;
            have_prev_reg <= 1'b1;
            if (sample > max_reg) begin
                max_reg <= sample;
            end
            if (sample < min_reg) begin
                min_reg <= sample;
            end
        end
    end

    // restoring divider, quotient shifts in where the dividend shifts out
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.div_load) begin
            cnt_reg <= CNT_W'(DVD_W);
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            dvd_reg <= {last_rise_reg - first_rise_reg, 8'd0};
            dsr_reg <= count_reg - COUNT_W'(1);
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], rem_ge};
            rem_reg <= rem_ge ? DSR_W'(rem_shift - {1'b0, dsr_reg}) : rem_shift[DSR_W-1:0];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_count_reg  <= count_reg;
            out_period_reg <= period_next;
            out_mode_reg   <= mode_next;
            out_high_reg   <= max_reg;
            out_low_reg    <= min_reg;
        end
    end

    assign rising_count = out_count_reg;
    assign period_q8    = out_period_reg;
    assign period_mode  = out_mode_reg;
    assign peak_high    = out_high_reg;
    assign peak_low     = out_low_reg;

endmodule

[rtl/wppm_controller.sv]
// sequencing state machine: sample intake, divider run, result handoff
// depends on wppm_pkg
module wppm_controller (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_last,
    output logic                   m_valid,
    input  logic                   m_ready,
    output wppm_pkg::wppm_cmd_t    cmd,
    input  wppm_pkg::wppm_status_t status
);
    import wppm_pkg::*;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_LOAD,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   in_take;
    logic   out_free;

    assign s_ready  = (state_reg == ST_RUN);
    assign in_take  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_RUN: begin
                cmd.track = in_take;
                if (in_take && s_last) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = !status.div_done;
                if (status.div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[rtl/waveform_period_and_peak_meter.sv]
// top level of the waveform period and peak meter
// depends on wppm_pkg, wppm_controller, wppm_datapath
//
//   channel   direction   ports                                  moves
//   s_        in          s_valid s_ready s_sample s_last        one sample request
//   m_        out         m_valid m_ready m_rising_count ...     one result per capture
//   cfg_      in          cfg_valid cfg_ready cfg_data           threshold write
//
// a sample is taken every cycle while a capture is running
// the last sample starts a bit-serial divide, one quotient bit per cycle over
// log2(MAX_SAMPLES)+8 bits; s_ready returns once the load, the divide and the
// result handoff are done
// the result waits in an output register while the next capture runs; only that
// capture's handoff stalls until m_ready frees the register
module waveform_period_and_peak_meter #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // sample channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [wppm_pkg::SAMPLE_W-1:0]     s_sample,
    input  logic                              s_last,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [wppm_pkg::COUNT_W-1:0]      m_rising_count,
    output logic [wppm_pkg::PERIOD_W-1:0]     m_period_q8,
    output logic [wppm_pkg::MODE_W-1:0]       m_period_mode,
    output logic [wppm_pkg::SAMPLE_W-1:0]     m_peak_high,
    output logic [wppm_pkg::SAMPLE_W-1:0]     m_peak_low,
    // threshold write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wppm_pkg::THRESH_W-1:0]     cfg_data
);
    import wppm_pkg::*;

    // reset is synchronous active low: threshold back to 128, capture state cleared
    wppm_cmd_t    cmd;
    wppm_status_t status;

    // threshold writes are always taken; they must only arrive while idle, which the block itself does not enforce
    assign cfg_ready = 1'b1;

    // sequencing: intake, divider run, result handoff
    wppm_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_last  (s_last),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // crossing and peak tracking, divider and result register
    wppm_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .sample       (s_sample),
        .rising_count (m_rising_count),
        .period_q8    (m_period_q8),
        .period_mode  (m_period_mode),
        .peak_high    (m_peak_high),
        .peak_low     (m_peak_low)
    );

endmodule

[verif/tb_waveform_period_and_peak_meter.sv]
// self-checking testbench for waveform_period_and_peak_meter
// a sample-level predictor of the crossing and peak tracking checks each result record
// depends on wppm_pkg and the waveform_period_and_peak_meter rtl
module tb_waveform_period_and_peak_meter;
    import wppm_pkg::*;

    localparam int MAX_SAMPLES  = 1024;
    localparam int INDEX_MAX    = MAX_SAMPLES - 1;
    // drain wait, long enough for the end of capture to finish with margin
    localparam int DRAIN_CYCLES = 40;
    // cycles in which no request moves on any channel before the run is declared hung
    localparam int STALL_LIMIT  = 1000;
    localparam int PRINT_LIMIT  = 40;

    typedef enum int {WAVE_SQUARE, WAVE_SAW, WAVE_NOISE, WAVE_DITHER} wave_kind_t;

    // one capture summary as the meter reports it
    typedef struct {
        logic [COUNT_W-1:0]  rising_count;
        logic [PERIOD_W-1:0] period_q8;
        logic [MODE_W-1:0]   period_mode;
        logic [SAMPLE_W-1:0] peak_high;
        logic [SAMPLE_W-1:0] peak_low;
    } meter_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [SAMPLE_W-1:0]   s_sample  = '0;
    logic                  s_last    = 1'b0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [COUNT_W-1:0]    m_rising_count;
    logic [PERIOD_W-1:0]   m_period_q8;
    logic [MODE_W-1:0]     m_period_mode;
    logic [SAMPLE_W-1:0]   m_peak_high;
    logic [SAMPLE_W-1:0]   m_peak_low;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [THRESH_W-1:0]   cfg_data  = '0;

    waveform_period_and_peak_meter #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_rising_count (m_rising_count),
        .m_period_q8    (m_period_q8),
        .m_period_mode  (m_period_mode),
        .m_peak_high    (m_peak_high),
        .m_peak_low     (m_peak_low),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // predictor copy of the threshold register and of the capture state
    logic [THRESH_W-1:0] threshold_reg;
    logic [SAMPLE_W-1:0] prev_code;
    logic                have_prev;
    logic [COUNT_W-1:0]  code_index;
    logic [COUNT_W-1:0]  rise_total;
    logic [COUNT_W-1:0]  first_rise_at;
    logic [COUNT_W-1:0]  last_rise_at;
    logic [COUNT_W-1:0]  first_fall_at;
    logic                fall_seen;
    logic [SAMPLE_W-1:0] max_code;
    logic [SAMPLE_W-1:0] min_code;

    meter_result_t       expected_results[$];
    logic [SAMPLE_W-1:0] capture_codes[$];

    int  mismatches  = 0;
    int  sent_items  = 0;
    int  stall_left  = 0;
    // when set neither side idles, giving stretches of full-rate traffic
    bit  calm        = 1'b0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic clear_capture();
        prev_code     = '0;
        have_prev     = 1'b0;
        code_index    = '0;
        rise_total    = '0;
        first_rise_at = '0;
        last_rise_at  = '0;
        first_fall_at = '0;
        fall_seen     = 1'b0;
        max_code      = '0;
        min_code      = '1;
    endtask

    // fold one accepted sample into the capture; on the last one queue the summary
    task automatic track_sample(input logic [SAMPLE_W-1:0] code, input logic lst);
        meter_result_t res;
        logic          prev_hi;
        logic          cur_hi;
        int unsigned   span;
        int unsigned   period;
        logic [MODE_W-1:0] mode;
        if (have_prev) begin
            prev_hi = {1'b0, prev_code} >= threshold_reg;
            cur_hi  = {1'b0, code} >= threshold_reg;
            // rising crossing takes the index of the sample below the threshold
            if (!prev_hi && cur_hi) begin
                if (rise_total == 0)
                    first_rise_at = code_index;
                last_rise_at = code_index;
                if (rise_total != COUNT_MAX)
                    rise_total++;
            end
            if (prev_hi && !cur_hi && !fall_seen) begin
                first_fall_at = code_index;
                fall_seen     = 1'b1;
            end
            // index sticks at the top for overlong captures
            if (code_index != INDEX_MAX)
                code_index++;
        end else begin
            code_index = '0;
        end
        prev_code = code;
        have_prev = 1'b1;
        if (code > max_code)
            max_code = code;
        if (code < min_code)
            min_code = code;
        if (lst) begin
            period = 0;
            mode   = MODE_INVALID;
            if (rise_total > 2) begin
                // mean rising interval over all crossings
                span   = (int'(last_rise_at) - int'(first_rise_at)) * 256;
                period = span / (int'(rise_total) - 1);
                mode   = MODE_MEAN;
            end else if (rise_total > 0 && fall_seen) begin
                // twice the distance between first rise and first fall, either order
                if (first_fall_at >= first_rise_at)
                    span = int'(first_fall_at) - int'(first_rise_at);
                else
                    span = int'(first_rise_at) - int'(first_fall_at);
                period = span * 512;
                mode   = MODE_HALF;
            end
            if (period > PERIOD_MAX)
                period = PERIOD_MAX;
            res.rising_count = rise_total;
            res.period_q8    = period[PERIOD_W-1:0];
            res.period_mode  = mode;
            res.peak_high    = max_code;
            res.peak_low     = min_code;
            expected_results.push_back(res);
            clear_capture();
        end
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // one sample request; valid stays up after acceptance so the next call can
    // reuse it back to back, and wait_idle drops it
    task automatic send_sample(input logic [SAMPLE_W-1:0] code, input logic lst);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= code;
        s_last   <= lst;
        do @(posedge aclk); while (!s_ready);
        track_sample(code, lst);
        sent_items++;
    endtask

    // send the queued capture with the flag on its final sample
    task automatic play_capture();
        foreach (capture_codes[i])
            send_sample(capture_codes[i], i == capture_codes.size() - 1);
        capture_codes.delete();
    endtask

    // block is idle once every summary is back and the divider has had time to finish
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [THRESH_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        threshold_reg = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] wave_code(wave_kind_t kind, int i, int per,
                                                       int lo, int hi);
        int v;
        case (kind)
            WAVE_SQUARE: v = ((i % per) < per / 2) ? hi : lo;
            WAVE_SAW:    v = lo + (hi - lo) * (i % per) / per;
            WAVE_NOISE:  v = $urandom_range(0, 255);
            default:     v = hi - 1 + int'($urandom_range(0, 2));
        endcase
        // occasional small jitter on the shaped waves
        if (kind != WAVE_NOISE && $urandom_range(0, 7) == 0)
            v = v + int'($urandom_range(0, 4)) - 2;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[SAMPLE_W-1:0];
    endfunction

    // result side: compare every accepted summary, then pick the next ready level
    always @(posedge aclk) begin
        meter_result_t want;
        if (m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, rising_count", m_rising_count, 0);
            end else begin
                want = expected_results.pop_front();
                if (m_rising_count !== want.rising_count)
                    report_mismatch("rising_count", m_rising_count, want.rising_count);
                if (m_period_q8 !== want.period_q8)
                    report_mismatch("period_q8", m_period_q8, want.period_q8);
                if (m_period_mode !== want.period_mode)
                    report_mismatch("period_mode", m_period_mode, want.period_mode);
                if (m_peak_high !== want.peak_high)
                    report_mismatch("peak_high", m_peak_high, want.peak_high);
                if (m_peak_low !== want.peak_low)
                    report_mismatch("peak_low", m_peak_low, want.peak_low);
            end
        end
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // hang detector: counts cycles in which no request moves on any channel
    initial begin
        int quiet;
        quiet = 0;
        wait (aresetn === 1'b1);
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
        $display("waveform_period_and_peak_meter regression: fail");
        $finish;
    end

    // crossing basics at the reset threshold: equality counts as above,
    // a lone rise or lone fall gives an invalid period, fall may come before rise
    task automatic test_crossing_basics();
        capture_codes = '{8'd200};
        play_capture();
        capture_codes = '{8'd0, 8'd255};
        play_capture();
        capture_codes = '{8'd255, 8'd0};
        play_capture();
        capture_codes = '{8'd127, 8'd128, 8'd127};
        play_capture();
        capture_codes = '{8'd200, 8'd10, 8'd10, 8'd10, 8'd200};
        play_capture();
        capture_codes = '{8'd0, 8'd200, 8'd0, 8'd200, 8'd0, 8'd200};
        play_capture();
        capture_codes = '{8'd127, 8'd128, 8'd127, 8'd128, 8'd127};
        play_capture();
    endtask

    // threshold extremes: zero puts every sample above, 256 puts none there
    task automatic test_threshold_extremes();
        write_threshold(9'd0);
        capture_codes = '{8'd0, 8'd255, 8'd0};
        play_capture();
        write_threshold(9'd256);
        capture_codes = '{8'd0, 8'd255, 8'd0, 8'd255};
        play_capture();
        write_threshold(9'd255);
        capture_codes = '{8'd254, 8'd255, 8'd254};
        play_capture();
        write_threshold(9'd1);
        capture_codes = '{8'd1, 8'd0, 8'd1, 8'd0, 8'd1, 8'd0, 8'd1};
        play_capture();
        write_threshold(THRESH_RESET);
    endtask

    // overlong capture: the index sticks at the top, giving the widest half period
    task automatic test_overlong_capture();
        capture_codes.push_back(8'd255);
        for (int i = 0; i < 1030; i++)
            capture_codes.push_back(8'd0);
        capture_codes.push_back(8'd255);
        play_capture();
    endtask

    // random waveforms under several thresholds, mostly short captures
    task automatic test_random_captures();
        int          phase_items;
        int          phase_caps;
        int          len;
        int          per;
        int          lo;
        int          hi;
        int          r;
        logic [THRESH_W-1:0] thr;
        wave_kind_t  kind;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       thr = 9'd0;
                1:       thr = 9'd256;
                2:       thr = 9'd255;
                3:       thr = 9'd1;
                default: thr = THRESH_W'($urandom_range(0, 256));
            endcase
            write_threshold(thr);
            phase_items = 0;
            phase_caps  = 0;
            while (phase_items < 60 || phase_caps < 4) begin
                calm = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 99);
                if (r < 90)
                    len = $urandom_range(1, 24);
                else
                    len = $urandom_range(25, 120);
                kind = wave_kind_t'($urandom_range(0, 3));
                per  = $urandom_range(2, 12);
                // mostly straddle the threshold so crossings actually happen
                if (thr >= 1 && thr <= 255 && $urandom_range(0, 9) < 7) begin
                    lo = $urandom_range(0, thr - 1);
                    hi = $urandom_range(thr, 255);
                end else begin
                    lo = $urandom_range(0, 255);
                    hi = $urandom_range(lo, 255);
                end
                if (kind == WAVE_DITHER)
                    hi = (thr > 255) ? 255 : int'(thr);
                for (int i = 0; i < len; i++)
                    capture_codes.push_back(wave_code(kind, i, per, lo, hi));
                play_capture();
                phase_items += len;
                phase_caps++;
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        threshold_reg = THRESH_RESET;
        clear_capture();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_crossing_basics();
        test_threshold_extremes();
        test_overlong_capture();
        test_random_captures();

        wait_idle();
        if (expected_results.size() != 0)
            report_mismatch("results still outstanding", 0, expected_results.size());
        if (mismatches == 0) begin
            $display("waveform_period_and_peak_meter regression: pass");
        end else begin
            $display("waveform_period_and_peak_meter regression: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/wppm_pkg.sv
rtl/wppm_datapath.sv
rtl/wppm_controller.sv
rtl/waveform_period_and_peak_meter.sv
verif/tb_waveform_period_and_peak_meter.sv
